// ----- design/hsnl_pkg.sv -----
// Shared types and constants of the noise level unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package hsnl_pkg;

    // Field and state widths.
    localparam int LEN_W      = 13;
    localparam int NAVG_W     = 16;
    localparam int SUM_W      = 36;
    localparam int SQ_W       = 60;
    localparam int OUT_W      = 24;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;

    // Multiplier and partial product widths.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int K_W    = 2 * LEN_W;
    localparam int CL_W   = K_W + NAVG_W;
    localparam int CR_W   = LEN_W + NAVG_W + 1;
    localparam int S2_W   = 2 * SUM_W;
    localparam int ACC_W  = 104;

    // Division runs one quotient bit per cycle over the whole sum.
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Block length limits and the start of the stop test window.
    localparam logic [LEN_W-1:0] MAX_BLOCK      = 13'd4096;
    localparam logic [LEN_W-1:0] MIN_BLOCK      = 13'd2;
    localparam logic [LEN_W-1:0] MIN_TEST_INDEX = 13'd5;
    localparam int               LEN_RATIO      = 5;

    // Configuration register indexes and reset values.
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_LENGTH   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_AVERAGES_COUNT = 1'b1;
    localparam logic [LEN_W-1:0]      RESET_BLOCK_LENGTH = 13'd4096;
    localparam logic [NAVG_W-1:0]     RESET_AVERAGES     = 16'd1;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_K,
        OP_CL,
        OP_CR,
        OP_S2A,
        OP_S2B,
        OP_S2C,
        OP_L0,
        OP_L1,
        OP_L2,
        OP_L3,
        OP_R0,
        OP_R1,
        OP_R2,
        OP_CMP,
        OP_STEP,
        OP_DIV,
        OP_PUT
    } t_op;

    // Status returned by the datapath.
    typedef struct packed {
        logic test_en;
        logic last;
        logic out_full;
    } t_status;

endpackage

`default_nettype wire

// ----- design/hsnl_ctrl.sv -----
// Controller of the noise level unit: sequences the multiply steps, the
// stop compare, the block end and the serial division. Depends on hsnl_pkg.
`default_nettype none

module hsnl_ctrl
    import hsnl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_op     o_op
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_K,
        ST_CL,
        ST_CR,
        ST_S2A,
        ST_S2B,
        ST_S2C,
        ST_L0,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_R0,
        ST_R1,
        ST_R2,
        ST_CMP,
        ST_STEP,
        ST_DIV,
        ST_PUT
    } t_state;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt;

    // Next state and the operation for this cycle.
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_op    = OP_SQ;
                n_state = i_status.test_en ? ST_K : ST_STEP;
            end
            ST_K:   begin o_op = OP_K;   n_state = ST_CL;  end
            ST_CL:  begin o_op = OP_CL;  n_state = ST_CR;  end
            ST_CR:  begin o_op = OP_CR;  n_state = ST_S2A; end
            ST_S2A: begin o_op = OP_S2A; n_state = ST_S2B; end
            ST_S2B: begin o_op = OP_S2B; n_state = ST_S2C; end
            ST_S2C: begin o_op = OP_S2C; n_state = ST_L0;  end
            ST_L0:  begin o_op = OP_L0;  n_state = ST_L1;  end
            ST_L1:  begin o_op = OP_L1;  n_state = ST_L2;  end
            ST_L2:  begin o_op = OP_L2;  n_state = ST_L3;  end
            ST_L3:  begin o_op = OP_L3;  n_state = ST_R0;  end
            ST_R0:  begin o_op = OP_R0;  n_state = ST_R1;  end
            ST_R1:  begin o_op = OP_R1;  n_state = ST_R2;  end
            ST_R2:  begin o_op = OP_R2;  n_state = ST_CMP; end
            ST_CMP: begin o_op = OP_CMP; n_state = ST_STEP; end
            ST_STEP: begin
                o_op    = OP_STEP;
                n_state = i_status.last ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                o_op    = OP_DIV;
                n_state = (r_cnt == DIV_LAST) ? ST_PUT : ST_DIV;
            end
            ST_PUT: begin
                // Wait while the held output word is not being taken.
                if (!i_status.out_full) begin
                    o_op    = OP_PUT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register and the division step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == ST_DIV) ? r_cnt + DIV_CNT_W'(1) : '0;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

// ----- design/hsnl_dpath.sv -----
// Datapath of the noise level unit: configuration registers, running sums,
// the shared multiplier, the exact stop compare and the serial divider.
// Depends on hsnl_pkg.
`default_nettype none

module hsnl_dpath
    import hsnl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_op                    i_op,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_out_ready,
    output t_status                o_status,
    output logic                   o_out_valid,
    output logic [OUT_W-1:0]       o_out_data
);

    localparam int TW = LEN_W + 3;

    // Configuration and block state.
    logic [LEN_W-1:0]       r_len;
    logic [NAVG_W-1:0]      r_navg;
    logic [LEN_W-1:0]       r_j;
    logic [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]        r_sq;
    logic                   r_stopped;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic                   r_out_valid;

    // Working registers.
    logic [SAMPLE_BITS-1:0] r_s;
    logic [K_W-1:0]         r_k;
    logic [CL_W-1:0]        r_cl;
    logic [CR_W-1:0]        r_cr;
    logic [S2_W-1:0]        r_s2;
    logic [ACC_W-1:0]       r_acc;
    logic [LEN_W-1:0]       r_stop_j;
    logic [SUM_W-1:0]       r_quo;
    logic [LEN_W-1:0]       r_rem;
    logic [LEN_W-1:0]       r_dvs;
    logic [OUT_W-1:0]       r_out_data;

    logic [LEN_W-1:0]  len_eff;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  prod_ext;
    logic              gt;
    logic [LEN_W:0]    rem_sh;
    logic              rem_ge;
    logic [LEN_W-1:0]  rem_diff;

    // Effective block length, clamped to the supported range.
    always_comb begin
        if (r_len > MAX_BLOCK) begin
            len_eff = MAX_BLOCK;
        end else if (r_len < MIN_BLOCK) begin
            len_eff = MIN_BLOCK;
        end else begin
            len_eff = r_len;
        end
    end

    // Status for the controller.
    assign o_status.test_en = !r_stopped && (r_j > MIN_TEST_INDEX) &&
                              ((TW'(r_j) * TW'(LEN_RATIO)) > TW'(len_eff));
    assign o_status.last     = ({1'b0, r_j} + (LEN_W + 1)'(1)) >= {1'b0, len_eff};
    assign o_status.out_full = r_out_valid && !i_out_ready;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            OP_SQ: begin
                mul_a = MUL_W'(r_s);
                mul_b = MUL_W'(r_s);
            end
            OP_K: begin
                mul_a = MUL_W'(r_j);
                mul_b = MUL_W'(r_j - LEN_W'(1));
            end
            OP_CL: begin
                mul_a = MUL_W'(r_k);
                mul_b = MUL_W'(r_navg);
            end
            OP_CR: begin
                mul_a = MUL_W'(r_j);
                mul_b = MUL_W'(r_navg);
            end
            OP_S2A: begin
                mul_a = r_sum[MUL_W-1:0];
                mul_b = r_sum[MUL_W-1:0];
            end
            OP_S2B: begin
                mul_a = r_sum[MUL_W-1:0];
                mul_b = MUL_W'(r_sum[SUM_W-1:MUL_W]);
            end
            OP_S2C: begin
                mul_a = MUL_W'(r_sum[SUM_W-1:MUL_W]);
                mul_b = MUL_W'(r_sum[SUM_W-1:MUL_W]);
            end
            OP_L0: begin
                mul_a = r_sq[MUL_W-1:0];
                mul_b = r_cl[MUL_W-1:0];
            end
            OP_L1: begin
                mul_a = r_sq[MUL_W-1:0];
                mul_b = MUL_W'(r_cl[CL_W-1:MUL_W]);
            end
            OP_L2: begin
                mul_a = MUL_W'(r_sq[SQ_W-1:MUL_W]);
                mul_b = r_cl[MUL_W-1:0];
            end
            OP_L3: begin
                mul_a = MUL_W'(r_sq[SQ_W-1:MUL_W]);
                mul_b = MUL_W'(r_cl[CL_W-1:MUL_W]);
            end
            OP_R0: begin
                mul_a = r_s2[MUL_W-1:0];
                mul_b = MUL_W'(r_cr);
            end
            OP_R1: begin
                mul_a = r_s2[2*MUL_W-1:MUL_W];
                mul_b = MUL_W'(r_cr);
            end
            OP_R2: begin
                mul_a = MUL_W'(r_s2[S2_W-1:2*MUL_W]);
                mul_b = MUL_W'(r_cr);
            end
            default: ;
        endcase
    end

    assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_ext = ACC_W'(prod);

    // The accumulator holds left side minus right side of the stop test.
    assign gt = !r_acc[ACC_W-1] && (r_acc != '0);

    // One restoring division step.
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = LEN_W'(rem_sh - {1'b0, r_dvs});

    // Configuration, block state and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= RESET_BLOCK_LENGTH;
            r_navg      <= RESET_AVERAGES;
            r_j         <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_stopped   <= 1'b0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_BLOCK_LENGTH:   r_len  <= i_cfg_data[LEN_W-1:0];
                    CFG_AVERAGES_COUNT: r_navg <= i_cfg_data[NAVG_W-1:0];
                    default: ;
                endcase
            end

            if (i_op == OP_PUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (i_op)
                OP_SQ: begin
                    // Samples after a stop leave the sums alone.
                    if (!r_stopped) begin
                        r_sum <= r_sum + SUM_W'(r_s);
                        r_sq  <= r_sq + prod[SQ_W-1:0];
                    end
                end
                OP_CMP: begin
                    // On a stop the previous sample is taken back out of the sum.
                    if (gt) begin
                        r_sum     <= r_sum - SUM_W'(r_prev);
                        r_stopped <= 1'b1;
                    end
                end
                OP_STEP: begin
                    if (o_status.last) begin
                        r_j       <= '0;
                        r_sum     <= '0;
                        r_sq      <= '0;
                        r_stopped <= 1'b0;
                        r_prev    <= '0;
                    end else begin
                        r_j    <= r_j + LEN_W'(1);
                        r_prev <= r_s;
                    end
                end
                default: ;
            endcase
        end
    end

    // Products, compare accumulator and divider.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: r_s  <= i_sample;
            OP_K:    r_k  <= prod[K_W-1:0];
            OP_CL:   r_cl <= prod[CL_W-1:0];
            OP_CR:   r_cr <= prod[CR_W-1:0] + CR_W'(r_j) - CR_W'(1);
            OP_S2A:  r_s2 <= S2_W'(prod);
            OP_S2B:  r_s2 <= r_s2 + (S2_W'(prod) << (MUL_W + 1));
            OP_S2C:  r_s2 <= r_s2 + (S2_W'(prod) << (2 * MUL_W));
            OP_L0:   r_acc <= prod_ext;
            OP_L1:   r_acc <= r_acc + (prod_ext << MUL_W);
            OP_L2:   r_acc <= r_acc + (prod_ext << MUL_W);
            OP_L3:   r_acc <= r_acc + (prod_ext << (2 * MUL_W));
            OP_R0:   r_acc <= r_acc - prod_ext;
            OP_R1:   r_acc <= r_acc - (prod_ext << MUL_W);
            OP_R2:   r_acc <= r_acc - (prod_ext << (2 * MUL_W));
            OP_CMP: begin
                if (gt) begin
                    r_stop_j <= r_j;
                end
            end
            OP_STEP: begin
                // Start the division: held sum over the stop index, or over the length.
                if (o_status.last) begin
                    r_quo <= r_sum;
                    r_rem <= '0;
                    r_dvs <= r_stopped ? r_stop_j : len_eff;
                end
            end
            OP_DIV: begin
                r_quo <= {r_quo[SUM_W-2:0], rem_ge};
                r_rem <= rem_ge ? rem_diff : rem_sh[LEN_W-1:0];
            end
            OP_PUT:  r_out_data <= r_quo[OUT_W-1:0];
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- design/hildebrand_sekhon_noise_level_unit.sv -----
// Hildebrand-Sekhon noise level estimator, top level.
// Depends on hsnl_pkg, hsnl_ctrl and hsnl_dpath.
//
// Usage: feed one block of ascending-sorted power samples on the s_axis
// channel, one word per sample. After the block's last sample one word with
// the estimated mean noise level leaves on the m_axis channel. Registers are
// written through i_cfg_we/i_cfg_addr/i_cfg_data; the user must write them
// only while the block is idle; the block does not enforce it. Index 0 is
// the block length, index 1 the number of averages. A sample passes through
// load, square and step while the stop test is not armed (early in the block
// or after a stop), and also through the exact cross-multiplied compare
// while it is, in 13 steps on the single 32x32 multiplier. After the last
// sample the sum goes through a bit-serial division and the output register
// is loaded; the word is valid in the next cycle. The next sample is
// accepted while that word still waits. If the receiver stalls with a word
// held, the block finishes its division and then holds until the output
// register is free. Reset is synchronous: it clears the block state and
// sets the block length to 4096 and the number of averages to 1.
`default_nettype none

module hildebrand_sekhon_noise_level_unit
    import hsnl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // Fields from bit 0: noise_level.
    output logic [OUT_W-1:0]          m_axis_tdata,
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    t_op     op;
    t_status status;

    // Sequencer.
    hsnl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_op       (op)
    );

    // Arithmetic and state.
    hsnl_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
